// ===== rtl/rmw_alu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmw_alu_pkg
// Shared types and codes for the atomic read-modify-write execute unit.
// ----------------------------------------------------------------------------
package rmw_alu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned HalfW = 32;

  // Request operation codes; codes 12..15 are unused and get rejected.
  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_AND     = 4'd1,
    OP_OR      = 4'd2,
    OP_XOR     = 4'd3,
    OP_SMAX    = 4'd4,
    OP_SMIN    = 4'd5,
    OP_UMAX    = 4'd6,
    OP_UMIN    = 4'd7,
    OP_SWAP    = 4'd8,
    OP_CAS     = 4'd9,
    OP_CASPAIR = 4'd10,
    OP_DMA     = 4'd11
  } rmw_op_e;

  // Access width codes.
  typedef enum logic [1:0] {
    WD_BYTE   = 2'd0,
    WD_HALF   = 2'd1,
    WD_WORD   = 2'd2,
    WD_DOUBLE = 2'd3
  } rmw_width_e;

  // Operand counts that each operation class must carry.
  localparam logic [2:0] SrcCntBasic = 3'd2;
  localparam logic [2:0] SrcCntCas   = 3'd3;
  localparam logic [2:0] SrcCntPair  = 3'd5;
  localparam logic [1:0] DstCntPair  = 2'd2;

  typedef struct packed {
    logic [3:0]       req_type;
    logic [1:0]       width_code;
    logic             load_done;
    logic [2:0]       source_count;
    logic [1:0]       dest_count;
    logic [DataW-1:0] base_address;
    logic [DataW-1:0] old_first;
    logic [DataW-1:0] old_second;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic [DataW-1:0] operand_c;
    logic [DataW-1:0] operand_d;
  } rmw_req_t;

  typedef struct packed {
    logic             accepted;
    logic             address_valid;
    logic [DataW-1:0] access_address;
    logic             write_valid;
    logic [DataW-1:0] write_data_first;
    logic [DataW-1:0] write_data_second;
  } rmw_res_t;

  // Byte-lane mask for a width code.
  function automatic logic [DataW-1:0] width_mask(input logic [1:0] wc);
    logic [DataW-1:0] m;
    case (wc)
      WD_BYTE: m = {{(DataW-8){1'b0}}, 8'hFF};
      WD_HALF: m = {{(DataW-16){1'b0}}, 16'hFFFF};
      WD_WORD: m = {{(DataW-HalfW){1'b0}}, {HalfW{1'b1}}};
      default: m = {DataW{1'b1}};
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/rmw_alu_arith.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmw_alu_arith
// Add, logic and min/max datapath at 32-bit (zero-extended) or 64-bit width.
// ----------------------------------------------------------------------------
module rmw_alu_arith (
  input  logic [3:0]                     op_i,
  input  logic                           wide_i,
  input  logic [rmw_alu_pkg::DataW-1:0]  a_i,
  input  logic [rmw_alu_pkg::DataW-1:0]  b_i,
  output logic [rmw_alu_pkg::DataW-1:0]  result_o
);
  import rmw_alu_pkg::*;

  logic [DataW-1:0] mask;
  logic [DataW-1:0] top;
  logic [DataW-1:0] a_m;
  logic [DataW-1:0] b_m;
  logic [DataW-1:0] sum;
  logic             s_gt;
  logic             s_lt;
  logic             u_gt;
  logic             u_lt;
  logic [DataW-1:0] res;

  // Operand masking and sign-bit position
  assign mask = wide_i ? {DataW{1'b1}} : {{(DataW-HalfW){1'b0}}, {HalfW{1'b1}}};
  assign top  = wide_i ? {1'b1, {(DataW-1){1'b0}}}
                       : {{(DataW-HalfW){1'b0}}, 1'b1, {(HalfW-1){1'b0}}};
  assign a_m  = a_i & mask;
  assign b_m  = b_i & mask;
  assign sum  = a_m + b_m;

  // Flipping the sign bit turns signed order into unsigned order
  assign s_gt = (a_m ^ top) > (b_m ^ top);
  assign s_lt = (a_m ^ top) < (b_m ^ top);
  assign u_gt = a_m > b_m;
  assign u_lt = a_m < b_m;

  // Operation select
  always_comb begin
    case (op_i)
      OP_ADD:  res = sum;
      OP_AND:  res = a_m & b_m;
      OP_OR:   res = a_m | b_m;
      OP_XOR:  res = a_m ^ b_m;
      OP_SMAX: res = s_gt ? a_m : b_m;
      OP_SMIN: res = s_lt ? a_m : b_m;
      OP_UMAX: res = u_gt ? a_m : b_m;
      default: res = u_lt ? a_m : b_m;
    endcase
  end

  assign result_o = res & mask;

endmodule

// ===== rtl/rmw_alu_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmw_alu_exec
// Operand-count check, phase handling, compare-and-swap and result assembly.
// ----------------------------------------------------------------------------
module rmw_alu_exec (
  input  rmw_alu_pkg::rmw_req_t req_i,
  output rmw_alu_pkg::rmw_res_t res_o
);
  import rmw_alu_pkg::*;

  logic             ok;
  logic [DataW-1:0] m;
  logic [DataW-1:0] alu_res;
  logic             eq_first;
  logic             eq_second;

  rmw_alu_arith u_arith (
    .op_i     (req_i.req_type),
    .wide_i   (req_i.width_code == WD_DOUBLE),
    .a_i      (req_i.old_first),
    .b_i      (req_i.operand_a),
    .result_o (alu_res)
  );

  // Operand count check
  always_comb begin
    unique case (req_i.req_type) inside
      OP_ADD, OP_AND, OP_OR, OP_XOR, OP_SMAX, OP_SMIN, OP_UMAX, OP_UMIN,
      OP_SWAP, OP_DMA: ok = (req_i.source_count == SrcCntBasic);
      OP_CAS:          ok = (req_i.source_count == SrcCntCas);
      OP_CASPAIR:      ok = (req_i.source_count == SrcCntPair) &&
                            (req_i.dest_count == DstCntPair);
      default:         ok = 1'b0;
    endcase
  end

  // Width-masked compares for the cas forms
  assign m         = width_mask(req_i.width_code);
  assign eq_first  = (req_i.operand_a & m) == (req_i.old_first & m);
  assign eq_second = (req_i.operand_b & m) == (req_i.old_second & m);

  // Result assembly
  always_comb begin
    res_o = '0;
    if (ok) begin
      res_o.accepted       = 1'b1;
      res_o.access_address = req_i.base_address;
      if (!req_i.load_done) begin
        res_o.address_valid = 1'b1;
      end else begin
        case (req_i.req_type) inside
          OP_ADD, OP_AND, OP_OR, OP_XOR, OP_SMAX, OP_SMIN, OP_UMAX, OP_UMIN: begin
            res_o.write_valid      = 1'b1;
            res_o.write_data_first = alu_res;
          end
          OP_SWAP: begin
            res_o.write_valid      = 1'b1;
            res_o.write_data_first = req_i.operand_a;
          end
          OP_CAS: begin
            if (eq_first) begin
              res_o.write_valid      = 1'b1;
              res_o.write_data_first = req_i.operand_b & m;
            end
          end
          OP_CASPAIR: begin
            if (eq_first && eq_second) begin
              res_o.write_valid       = 1'b1;
              res_o.write_data_first  = req_i.operand_c & m;
              res_o.write_data_second = req_i.operand_d & m;
            end
          end
          default: ;  // dma data phase: address only
        endcase
      end
    end
  end

endmodule

// ===== rtl/atomic_rmw_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atomic_rmw_alu
// Execute unit for atomic read-modify-write requests: address phase and
// write-back value computation, one result beat per request beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------
//  request | in        | in_valid_i / in_ready_o | in_req_i  (rmw_req_t)
//  result  | out       | out_valid_o/out_ready_i | out_res_o (rmw_res_t)
//
//  A beat passes through the request register, then the result register.
//  One beat per cycle is sustained while out_ready_i is high; the request
//  register refills while the result register drains.
//  in_ready_o drops only when both registers hold beats and the result is
//  stalled; it follows out_ready_i combinationally.
//  Reset empties both registers; payload registers are not reset.
// ----------------------------------------------------------------------------
module atomic_rmw_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rmw_alu_pkg::rmw_req_t in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rmw_alu_pkg::rmw_res_t out_res_o
);
  import rmw_alu_pkg::*;

  rmw_req_t req_q;
  logic     req_valid_q;
  rmw_res_t res_d;
  rmw_res_t res_q;
  logic     res_valid_q;
  logic     res_ready;

  // Stage readiness
  assign res_ready  = !res_valid_q || out_ready_i;
  assign in_ready_o = !req_valid_q || res_ready;

  // Request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  // Single-pass compute
  rmw_alu_exec u_exec (
    .req_i (req_q),
    .res_o (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_res_o   = res_q;

  // Checks
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (req_valid_q && res_valid_q))
    else $error("request stalled with an empty stage");

  a_write_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.write_valid) |->
      (out_res_o.accepted && !out_res_o.address_valid))
    else $error("write beat without accepted data phase");

  a_addr_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.address_valid) |->
      (out_res_o.write_data_first == '0 && out_res_o.write_data_second == '0))
    else $error("address phase beat carries write data");

  a_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && res_ready) |=> out_valid_o)
    else $error("request beat lost between stages");

endmodule
